[design/mdfc_pkg.sv]
// Shared types and constants for the checked multiply-divide block.
`timescale 1ns / 1ps

package mdfc_pkg;

   // Fixed width of every operand and result field.
   localparam int FIELD_W = 64;
   // Default arithmetic width.
   localparam int OPERAND_WIDTH_DEF = 64;

   typedef enum logic [1:0] {
      OP_FLOOR     = 2'd0,
      OP_CEIL      = 2'd1,
      OP_FLOOR_SAT = 2'd2,
      OP_SPARE     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_SPARE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [FIELD_W-1:0] factor_a;
      logic [FIELD_W-1:0] factor_b;
      logic [FIELD_W-1:0] divisor;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_value;
      logic [FIELD_W-1:0] remainder_value;
      logic [1:0]         status;
   } rsp_type;

endpackage

[design/mdfc_mul.sv]
// Two-stage pipelined W x W unsigned multiplier built from half-width partial products.
`timescale 1ns / 1ps

module mdfc_mul #(
   parameter int W = mdfc_pkg::OPERAND_WIDTH_DEF
) (
   input  logic           clock,
   input  logic [W-1:0]   factor_a,
   input  logic [W-1:0]   factor_b,
   output logic [2*W-1:0] product
);

   localparam int H  = (W + 1) / 2;
   localparam int U  = W - H;
   localparam int W2 = 2 * W;

   logic [2*H-1:0] p00_ff, p00_in;
   logic [H+U-1:0] p01_ff, p01_in;
   logic [H+U-1:0] p10_ff, p10_in;
   logic [2*U-1:0] p11_ff, p11_in;
   logic [W2-1:0]  product_ff, product_in;

   // Form the four partial products of the low and high limbs.
   always_comb begin
      p00_in = factor_a[H-1:0] * factor_b[H-1:0];
      p01_in = factor_a[H-1:0] * factor_b[W-1:H];
      p10_in = factor_a[W-1:H] * factor_b[H-1:0];
      p11_in = factor_a[W-1:H] * factor_b[W-1:H];
   end

   // Align and add the partial products.
   always_comb begin
      product_in = W2'(p00_ff) + (W2'(p01_ff) << H) + (W2'(p10_ff) << H)
                 + (W2'(p11_ff) << (2 * H));
   end

   always_ff @(posedge clock) begin
      p00_ff     <= p00_in;
      p01_ff     <= p01_in;
      p10_ff     <= p10_in;
      p11_ff     <= p11_in;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

[design/checked_mul_div_floor_ceil.sv]
// Top level: pipelined checked multiply-divide with floor, ceil and saturating rounding.
// A request passes the input register, the multiplier stages, the divider stages and the output register to rsp_strobe.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The divider retires one quotient bit per stage, 2*OPERAND_WIDTH stages in all.
// Reset (synchronous, active high) clears all valid bits; results in flight are dropped.
`timescale 1ns / 1ps

module checked_mul_div_floor_ceil #(
   parameter int OPERAND_WIDTH = mdfc_pkg::OPERAND_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mdfc_pkg::req_type req_data,
   output logic              rsp_strobe,
   output mdfc_pkg::rsp_type rsp_data
);

   localparam int W  = OPERAND_WIDTH;
   localparam int N  = 2 * W;
   localparam int FW = mdfc_pkg::FIELD_W;

   typedef struct packed {
      logic [1:0]   op;
      logic         dz;
      logic         zf;
      logic [W-1:0] d;
   } side_type;

   typedef struct packed {
      logic [1:0]   op;
      logic         dz;
      logic         zf;
      logic [W-1:0] d;
      logic [N-1:0] num;
      logic [W-1:0] r;
      logic [W-1:0] q;
      logic         qnz;
   } div_type;

   // One restoring division step: shift in the next dividend bit, try the subtract.
   function automatic div_type div_step(input div_type s);
      div_type      t;
      logic [W:0]   rr;
      logic         qb;
      t  = s;
      rr = {s.r, s.num[N-1]};
      qb = s.r[W-1] || (rr >= {1'b0, s.d});
      if (qb) begin
         rr = rr - {1'b0, s.d};
      end
      t.num = s.num << 1;
      t.r   = rr[W-1:0];
      t.qnz = s.qnz | s.q[W-1];
      t.q   = {s.q[W-2:0], qb};
      return t;
   endfunction

   // Input stage.
   logic         s0_vld_ff, s0_vld_in;
   side_type     s0_side_ff, s0_side_in;
   logic [W-1:0] s0_a_ff, s0_b_ff;
   logic [W-1:0] a_in, b_in;

   // Stages alongside the multiplier.
   logic         s1_vld_ff, s2_vld_ff;
   side_type     s1_side_ff, s2_side_ff;
   logic [N-1:0] product;

   // Divider stages.
   div_type      div_load;
   div_type      pipe_in  [0:N-1];
   div_type      pipe_ff  [0:N-1];
   logic [N-1:0] pipe_vld_ff;

   // Output stage.
   logic              rsp_vld_ff, rsp_vld_in;
   mdfc_pkg::rsp_type rsp_ff, rsp_in;

   assign busy = 1'b0;

   // Mask operands to the working width and flag the special cases.
   always_comb begin
      s0_vld_in     = start && !busy;
      a_in          = req_data.factor_a[W-1:0];
      b_in          = req_data.factor_b[W-1:0];
      s0_side_in.op = req_data.opcode;
      s0_side_in.d  = req_data.divisor[W-1:0];
      s0_side_in.dz = (req_data.divisor[W-1:0] == '0);
      s0_side_in.zf = (a_in == '0) || (b_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= s0_vld_in;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s0_side_ff <= s0_side_in;
      s0_a_ff    <= a_in;
      s0_b_ff    <= b_in;
      s1_side_ff <= s0_side_ff;
      s2_side_ff <= s1_side_ff;
   end

   mdfc_mul #(
      .W(W)
   ) u_mul (
      .clock    (clock),
      .factor_a (s0_a_ff),
      .factor_b (s0_b_ff),
      .product  (product)
   );

   // Load the divider with the full product.
   always_comb begin
      div_load.op  = s2_side_ff.op;
      div_load.dz  = s2_side_ff.dz;
      div_load.zf  = s2_side_ff.zf;
      div_load.d   = s2_side_ff.d;
      div_load.num = product;
      div_load.r   = '0;
      div_load.q   = '0;
      div_load.qnz = 1'b0;
   end

   // Advance one quotient bit per stage.
   for (genvar k = 0; k < N; k++) begin : g_div
      if (k == 0) begin : g_load
         assign pipe_in[k] = div_load;
      end else begin : g_link
         assign pipe_in[k] = pipe_ff[k-1];
      end
      always_ff @(posedge clock) begin
         pipe_ff[k] <= div_step(pipe_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
      end else begin
         pipe_vld_ff <= {pipe_vld_ff[N-2:0], s2_vld_ff};
      end
   end

   // Round, check and saturate.
   always_comb begin
      logic [W-1:0]         mw;
      logic [W-1:0]         res;
      logic [W-1:0]         rem;
      mdfc_pkg::status_type st;
      div_type              f;
      f   = pipe_ff[N-1];
      mw  = '1;
      res = '0;
      rem = '0;
      st  = mdfc_pkg::ST_OK;
      if (f.dz) begin
         st = mdfc_pkg::ST_DIV_ZERO;
      end else if (f.zf) begin
         res = '0;
      end else if (f.qnz) begin
         st = mdfc_pkg::ST_OVERFLOW;
      end else if (f.op == mdfc_pkg::OP_CEIL && f.r != '0) begin
         if (f.q == mw) begin
            st = mdfc_pkg::ST_OVERFLOW;
         end else begin
            res = f.q + 1'b1;
            rem = f.r;
         end
      end else begin
         res = f.q;
         rem = f.r;
      end
      if (st != mdfc_pkg::ST_OK) begin
         res = (f.op == mdfc_pkg::OP_FLOOR_SAT) ? mw : '0;
         rem = '0;
      end
      rsp_vld_in             = pipe_vld_ff[N-1];
      rsp_in.result_value    = FW'(res);
      rsp_in.remainder_value = FW'(rem);
      rsp_in.status          = st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_data   = rsp_ff;

   // Divider leaves a remainder below the divisor.
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (pipe_vld_ff[N-1] && !pipe_ff[N-1].dz) |-> (pipe_ff[N-1].r < pipe_ff[N-1].d))
      else $error("remainder not below divisor");

   // Last divider stage feeds the result register.
   a_vld_to_rsp: assert property (@(posedge clock) disable iff (reset)
      pipe_vld_ff[N-1] |=> rsp_vld_ff)
      else $error("result lost after divider");

   // A failed request carries no remainder.
   a_fail_rem_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.status != mdfc_pkg::ST_OK) |-> (rsp_ff.remainder_value == '0))
      else $error("remainder on failed request");

   // A zero divisor always reports division by zero.
   a_dz_status: assert property (@(posedge clock) disable iff (reset)
      (pipe_vld_ff[N-1] && pipe_ff[N-1].dz) |=> (rsp_ff.status == mdfc_pkg::ST_DIV_ZERO))
      else $error("zero divisor not reported");

endmodule

[sim/checked_mul_div_floor_ceil_tb.sv]
// Self-checking testbench for the checked multiply-divide block.
`timescale 1ns / 1ps

module checked_mul_div_floor_ceil_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 160;
   localparam logic [63:0] ALL_ONES = {64{1'b1}};

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mdfc_pkg::req_type req_data;
   logic              rsp_strobe;
   mdfc_pkg::rsp_type rsp_data;

   mdfc_pkg::rsp_type quotient_q[$];
   int                error_count;
   int                cycle_count;

   checked_mul_div_floor_ceil uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("checked_mul_div_floor_ceil test failed");
         $finish;
      end
   end

   // Predict the rounded quotient, remainder and status of one request
   function automatic mdfc_pkg::rsp_type predict_muldiv(mdfc_pkg::req_type r);
      mdfc_pkg::rsp_type o;
      logic [127:0]      prod, quo, rem;
      o.result_value = '0;
      o.remainder_value = '0;
      o.status = mdfc_pkg::ST_OK;
      if (r.divisor == 0) begin
         o.status = mdfc_pkg::ST_DIV_ZERO;
      end else if (r.factor_a != 0 && r.factor_b != 0) begin
         prod = {64'd0, r.factor_a} * {64'd0, r.factor_b};
         quo = prod / {64'd0, r.divisor};
         rem = prod % {64'd0, r.divisor};
         if (quo[127:64] != 0) begin
            o.status = mdfc_pkg::ST_OVERFLOW;
         end else if (r.opcode == mdfc_pkg::OP_CEIL && rem != 0) begin
            if (quo[63:0] == ALL_ONES) begin
               o.status = mdfc_pkg::ST_OVERFLOW;
            end else begin
               o.result_value = quo[63:0] + 64'd1;
               o.remainder_value = rem[63:0];
            end
         end else begin
            o.result_value = quo[63:0];
            o.remainder_value = rem[63:0];
         end
      end
      if (o.status != mdfc_pkg::ST_OK) begin
         o.result_value = (r.opcode == mdfc_pkg::OP_FLOOR_SAT) ? ALL_ONES : 64'd0;
         o.remainder_value = '0;
      end
      return o;
   endfunction

   // Compare each result with the oldest expectation
   always @(posedge clock) begin
      mdfc_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (quotient_q.size() == 0) begin
            $error("unexpected result %h", rsp_data);
            error_count++;
         end else begin
            want = quotient_q.pop_front();
            if (rsp_data.result_value !== want.result_value) begin
               $error("result_value exp %h got %h", want.result_value,
                      rsp_data.result_value);
               error_count++;
            end
            if (rsp_data.remainder_value !== want.remainder_value) begin
               $error("remainder_value exp %h got %h", want.remainder_value,
                      rsp_data.remainder_value);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status exp %0d got %0d", want.status, rsp_data.status);
               error_count++;
            end
         end
      end
   end

   // Send one request, after a random gap when allowed, and record its expectation
   task automatic send_request(mdfc_pkg::opcode_type op, logic [63:0] a,
                               logic [63:0] b, logic [63:0] d, bit allow_gap = 1);
      int                gap;
      mdfc_pkg::req_type r;
      gap = allow_gap ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      r.opcode = op;
      r.factor_a = a;
      r.factor_b = b;
      r.divisor = d;
      start <= 1'b1;
      req_data <= r;
      quotient_q.push_back(predict_muldiv(r));
      // hold until the edge that accepts the request
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Operand with a random bit length so quotients often fit
   function automatic logic [63:0] rand_sized();
      int n;
      n = $urandom_range(1, 64);
      return rand64() >> (64 - n);
   endfunction

   function automatic mdfc_pkg::opcode_type rand_op();
      return mdfc_pkg::opcode_type'($urandom_range(0, 3));
   endfunction

   // Extremes and each special case
   task automatic test_directed();
      send_request(mdfc_pkg::OP_FLOOR, 64'd7, 64'd3, 64'd0, 0);
      send_request(mdfc_pkg::OP_FLOOR_SAT, ALL_ONES, ALL_ONES, 64'd0, 0);
      send_request(mdfc_pkg::OP_CEIL, 64'd0, 64'd9, 64'd4, 0);
      send_request(mdfc_pkg::OP_FLOOR_SAT, 64'd5, 64'd0, ALL_ONES, 0);
      send_request(mdfc_pkg::OP_FLOOR, ALL_ONES, ALL_ONES, ALL_ONES);
      send_request(mdfc_pkg::OP_CEIL, ALL_ONES, ALL_ONES, ALL_ONES);
      send_request(mdfc_pkg::OP_FLOOR, ALL_ONES, ALL_ONES, 64'd1);
      send_request(mdfc_pkg::OP_FLOOR_SAT, ALL_ONES, 64'd2, 64'd1);
      send_request(mdfc_pkg::OP_CEIL, ALL_ONES, 64'd2, 64'd2);
      // ceil at the maximum with no remainder
      send_request(mdfc_pkg::OP_CEIL, ALL_ONES, 64'd3, 64'd3);
      send_request(mdfc_pkg::OP_CEIL, ALL_ONES, 64'd4, 64'd3);
      send_request(mdfc_pkg::OP_FLOOR, ALL_ONES, 64'd4, 64'd3);
      send_request(mdfc_pkg::OP_CEIL, 64'd7, 64'd3, 64'd4);
      send_request(mdfc_pkg::OP_FLOOR, 64'd7, 64'd3, 64'd4);
      send_request(mdfc_pkg::OP_FLOOR_SAT, 64'd7, 64'd3, 64'd4);
      send_request(mdfc_pkg::OP_SPARE, 64'd7, 64'd3, 64'd4);
      send_request(mdfc_pkg::OP_SPARE, ALL_ONES, ALL_ONES, 64'd5);
      send_request(mdfc_pkg::OP_CEIL, 64'd1, 64'd1, ALL_ONES);
      send_request(mdfc_pkg::OP_FLOOR, 64'h8000_0000_0000_0000, 64'd2,
                   64'h8000_0000_0000_0000);
      send_request(mdfc_pkg::OP_CEIL, 64'd1, 64'd1, 64'd1);
   endtask

   // Random operands, mostly sized to give in-range quotients
   task automatic test_random();
      logic [63:0] a, b, d;
      for (int i = 0; i < 530; i++) begin
         case ($urandom_range(0, 9))
            0: begin
               a = rand64(); b = rand64(); d = rand64();
            end
            1: begin
               a = rand_sized(); b = rand_sized();
               d = ($urandom_range(0, 3) == 0) ? 64'd0 : rand_sized();
            end
            2: begin
               a = ($urandom_range(0, 1)) ? 64'd0 : rand64();
               b = (a != 0) ? 64'd0 : rand64();
               d = rand64();
            end
            default: begin
               a = rand64(); b = rand_sized();
               // divisor near one factor keeps the quotient close to the other
               d = b + 64'($urandom_range(0, 3)) - 64'd1;
               if (d == 0) d = 64'd1;
               if ($urandom_range(0, 1)) d = rand_sized() | 64'd1;
            end
         endcase
         send_request(rand_op(), a, b, d, $urandom_range(0, 3) != 0);
      end
   endtask

   initial begin
      error_count = 0;
      cycle_count = 0;
      start <= 1'b0;
      req_data <= '0;
      reset <= 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      start <= 1'b0;
      while (quotient_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("checked_mul_div_floor_ceil test passed");
      end else begin
         $display("checked_mul_div_floor_ceil test failed");
      end
      $finish;
   end

endmodule

[files.f]
design/mdfc_pkg.sv
design/mdfc_mul.sv
design/checked_mul_div_floor_ceil.sv
sim/checked_mul_div_floor_ceil_tb.sv
